[sv/mrr_pkg.sv]
// Package for the Modbus RTU response receiver: word types, codes and the CRC-16 byte fold.
// Has no dependencies. All other files of the block import it.
package mrr_pkg;

  // Register indexes on the configuration port
  localparam logic CFG_TIMEOUT_TICKS = 1'b0;
  localparam logic CFG_RETRY_LIMIT   = 1'b1;

  // Register reset values
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;
  localparam logic [3:0]  RETRY_LIMIT_RESET   = 4'd3;

  // Frame constants
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [8:0]  LEN_UNKNOWN  = 9'h1FF;
  localparam logic [8:0]  LEN_FC03_HDR = 9'd5;
  localparam logic [8:0]  LEN_FC10     = 9'd8;
  localparam logic [8:0]  LEN_EXCEPT   = 9'd5;
  localparam logic [8:0]  FC_POS       = 9'd2;
  localparam logic [8:0]  DECODE_POS   = 9'd3;
  localparam logic [15:0] TICK_MAX     = 16'hFFFF;

  // Function codes
  localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
  localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;
  localparam logic [7:0] FC_EXC_READ      = 8'h83;
  localparam logic [7:0] FC_EXC_WRITE     = 8'h86;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_CRC_ERR    = 3'd1,
    ST_TIMEOUT    = 3'd2,
    ST_UNKNOWN    = 3'd3,
    ST_RETRANSMIT = 3'd4
  } status_t;

  typedef enum logic {
    RX_IDLE = 1'b0,
    RX_BUSY = 1'b1
  } rx_state_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] data_byte;
    logic [7:0] request_length;
  } req_word_t;

  typedef struct packed {
    status_t    status;
    logic [8:0] frame_length;
    logic [3:0] attempt_number;
  } rsp_word_t;

  // Current configuration, from register block to engine
  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [3:0]  retry_limit;
  } cfg_t;

  // Result of one item, from engine to output register
  typedef struct packed {
    logic      valid;
    rsp_word_t word;
  } result_t;

  // One byte folded into the reflected CRC-16, LSB first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[sv/modbus_rtu_response_receiver.sv]
// Top level of the Modbus RTU response receiver: input register, frame engine, result register.
// Depends on mrr_pkg, mrr_cfg and mrr_engine.
//
//  channel | direction | handshake           | word
//  req     | in        | req_valid/req_stall | req_word_t (opcode, data_byte, request_length)
//  rsp     | out       | rsp_valid/rsp_stall | rsp_word_t (status, frame_length, attempt_number)
//  cfg     | in        | cfg_write           | cfg_index, cfg_data
//
// One word per cycle unless a stall on rsp holds the input register; each result is registered.
// The rate is set by the single engine pass between the input and result registers.
// A stall on rsp holds a word in the input register only when that word makes a result.
// Reset (rst, synchronous) idles the engine and loads the register defaults.
module modbus_rtu_response_receiver
  import mrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_word_t   req_word,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_word_t   rsp_word,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t      cfg;
  result_t   result;
  logic      stage_valid;
  req_word_t stage_word;
  logic      out_free;
  logic      advance;

  mrr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mrr_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .step   (stage_valid && advance),
    .item   (stage_word),
    .cfg    (cfg),
    .result (result)
  );

  // Staged word moves on unless it has a result and the output is full
  assign out_free  = !rsp_valid || !rsp_stall;
  assign advance   = !result.valid || out_free;
  assign req_stall = stage_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!req_stall) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      stage_word <= req_word;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stage_valid && result.valid && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid && result.valid && out_free) begin
      rsp_word <= result.word;
    end
  end

endmodule

[sv/mrr_cfg.sv]
// Configuration registers of the Modbus RTU response receiver.
// Depends on mrr_pkg for register indexes, reset values and cfg_t.
module mrr_cfg
  import mrr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  // Register writes, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TIMEOUT_TICKS_RESET;
      cfg.retry_limit   <= RETRY_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        CFG_RETRY_LIMIT:   cfg.retry_limit   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

[sv/mrr_engine.sv]
// Frame engine: attempt state, byte counting, CRC, length decode and tick timeout.
// Depends on mrr_pkg. Result is combinational from state, configuration and the staged word.
module mrr_engine
  import mrr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  req_word_t item,
  input  cfg_t      cfg,
  output result_t   result
);

  rx_state_t   state, state_next;
  logic [8:0]  byte_count;
  logic [8:0]  expected_length;
  logic [7:0]  function_code;
  logic [15:0] running_crc;
  logic [15:0] elapsed_ticks;
  logic [3:0]  attempt_count;
  logic [7:0]  saved_request_length;

  logic [8:0]  count_new;
  logic [15:0] crc_new;
  logic [8:0]  decoded_length;
  logic        fc_unknown;
  logic [8:0]  expected_new;
  logic        frame_done;
  logic [15:0] ticks_new;
  logic        expire;
  logic        retry_ok;
  logic        busy;

  assign busy = (state == RX_BUSY);

  // Byte path: saturating count, CRC fold
  assign count_new = (byte_count != LEN_UNKNOWN) ? byte_count + 9'd1 : byte_count;
  assign crc_new   = crc_fold(running_crc, item.data_byte);

  // Length decode from the stored function code, used at the third byte
  always_comb begin
    decoded_length = LEN_UNKNOWN;
    fc_unknown     = 1'b0;
    case (function_code) inside
      FC_READ_HOLDING:           decoded_length = LEN_FC03_HDR + {1'b0, item.data_byte};
      FC_WRITE_SINGLE:           decoded_length = {1'b0, saved_request_length};
      FC_WRITE_MULTI:            decoded_length = LEN_FC10;
      FC_EXC_READ, FC_EXC_WRITE: decoded_length = LEN_EXCEPT;
      default:                   fc_unknown     = 1'b1;
    endcase
  end

  assign expected_new = (count_new == DECODE_POS) ? decoded_length : expected_length;
  assign frame_done   = !(fc_unknown && count_new == DECODE_POS) &&
                        (count_new >= expected_new);

  // Tick path: saturating count, expiry and retry decision
  assign ticks_new = (elapsed_ticks != TICK_MAX) ? elapsed_ticks + 16'd1 : elapsed_ticks;
  assign expire    = (ticks_new >= cfg.timeout_ticks);
  assign retry_ok  = ({1'b0, attempt_count} + 5'd1) < {1'b0, cfg.retry_limit};

  // Next state
  always_comb begin
    state_next = state;
    case (item.opcode)
      OP_START: state_next = RX_BUSY;
      OP_BYTE: begin
        if (busy && ((fc_unknown && count_new == DECODE_POS) || frame_done)) begin
          state_next = RX_IDLE;
        end
      end
      OP_TICK: begin
        if (busy && expire && !retry_ok) begin
          state_next = RX_IDLE;
        end
      end
      default: ;
    endcase
  end

  // Result word
  always_comb begin
    result.valid               = 1'b0;
    result.word.status         = ST_OK;
    result.word.frame_length   = byte_count;
    result.word.attempt_number = attempt_count;
    case (item.opcode)
      OP_BYTE: begin
        result.word.frame_length = count_new;
        if (busy && fc_unknown && count_new == DECODE_POS) begin
          result.valid       = 1'b1;
          result.word.status = ST_UNKNOWN;
        end else if (busy && frame_done) begin
          result.valid       = 1'b1;
          result.word.status = (crc_new == 16'h0000) ? ST_OK : ST_CRC_ERR;
        end
      end
      OP_TICK: begin
        if (busy && expire) begin
          result.valid       = 1'b1;
          result.word.status = retry_ok ? ST_RETRANSMIT : ST_TIMEOUT;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RX_IDLE;
    end else if (step) begin
      state <= state_next;
    end
  end

  // Attempt registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count           <= '0;
      expected_length      <= LEN_UNKNOWN;
      function_code        <= '0;
      running_crc          <= CRC_INIT;
      elapsed_ticks        <= '0;
      attempt_count        <= '0;
      saved_request_length <= '0;
    end else if (step) begin
      case (item.opcode)
        OP_START: begin
          attempt_count        <= '0;
          saved_request_length <= item.request_length;
          byte_count           <= '0;
          expected_length      <= LEN_UNKNOWN;
          function_code        <= '0;
          running_crc          <= CRC_INIT;
          elapsed_ticks        <= '0;
        end
        OP_BYTE: begin
          if (busy) begin
            byte_count      <= count_new;
            running_crc     <= crc_new;
            expected_length <= expected_new;
            if (count_new == FC_POS) begin
              function_code <= item.data_byte;
            end
          end
        end
        OP_TICK: begin
          if (busy) begin
            if (expire && retry_ok) begin
              // New attempt
              attempt_count   <= attempt_count + 4'd1;
              byte_count      <= '0;
              expected_length <= LEN_UNKNOWN;
              function_code   <= '0;
              running_crc     <= CRC_INIT;
              elapsed_ticks   <= '0;
            end else begin
              elapsed_ticks <= ticks_new;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[sv/mrr_checker.sv]
// Port-level checks on the Modbus RTU response receiver, bound to the top level.
// Depends on mrr_pkg for rsp_word_t and the status codes.
module mrr_checker
  import mrr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_word_t rsp_word
);

  // A stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
    else $error("rsp word changed while stalled");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp valid after reset");

  // Unknown function is reported at the third byte
  a_unknown_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.status == ST_UNKNOWN |-> rsp_word.frame_length == 9'd3)
    else $error("unknown function with frame length other than 3");

  // A judged frame has at least its header
  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_word.status == ST_OK || rsp_word.status == ST_CRC_ERR)
      |-> rsp_word.frame_length >= 9'd3)
    else $error("judged frame shorter than 3 bytes");

endmodule

bind modbus_rtu_response_receiver mrr_checker u_mrr_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_word  (rsp_word)
);

[tb/modbus_rtu_response_receiver_tb.sv]
`timescale 1ns / 100ps
// Testbench for the Modbus RTU response receiver: queued request words, a clocked driver
// and result checker, and a word-level predictor of framing, CRC-16 and retry handling.
// Depends on mrr_pkg and modbus_rtu_response_receiver.
module modbus_rtu_response_receiver_tb;
  import mrr_pkg::*;

  // Opcode value outside the defined set, ignored by the block
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 7;
  localparam int PHASE_WORDS = 250;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_word_t   req_word = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_word_t   rsp_word;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_TIMEOUT_TICKS;
  logic [15:0] cfg_data = '0;

  modbus_rtu_response_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Stimulus and result bookkeeping
  req_word_t  queued_req[$];
  rsp_word_t  awaited_rsp[$];
  logic [7:0] frame_bytes[$];
  int         quiet_left[2];
  int         hold_left = 0;
  int         mismatches = 0;
  int         words_taken = 0;
  int         results_seen = 0;
  int         status_seen[5];
  int         settings_used = 1;

  // Predicted receiver state and register copies
  logic [15:0] timeout_setting = TIMEOUT_TICKS_RESET;
  logic [3:0]  retry_setting = RETRY_LIMIT_RESET;
  bit          rx_busy = 1'b0;
  logic [8:0]  rx_count = '0;
  logic [8:0]  rx_expect_len = LEN_UNKNOWN;
  logic [7:0]  rx_func = '0;
  logic [15:0] rx_crc = 16'hFFFF;
  logic [15:0] rx_ticks = '0;
  logic [3:0]  rx_attempt = '0;
  logic [7:0]  rx_req_len = '0;

  // Reflected CRC-16, one data bit at a time into the feedback
  function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ b[i]) begin
        c = (c >> 1) ^ 16'hA001;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic void open_attempt();
    rx_count = '0;
    rx_expect_len = LEN_UNKNOWN;
    rx_func = '0;
    rx_crc = 16'hFFFF;
    rx_ticks = '0;
  endfunction

  function automatic rsp_word_t result_of(input status_t s);
    rsp_word_t r;
    r.status = s;
    r.frame_length = rx_count;
    r.attempt_number = rx_attempt;
    return r;
  endfunction

  // Advance the predicted receiver by one word; returns 1 when a result is due
  function automatic bit predict_rx_result(input req_word_t w, output rsp_word_t r);
    r = '0;
    if (w.opcode == OP_START) begin
      rx_busy = 1'b1;
      rx_attempt = '0;
      rx_req_len = w.request_length;
      open_attempt();
      return 1'b0;
    end
    if (!rx_busy) return 1'b0;
    if (w.opcode == OP_BYTE) begin
      if (rx_count != 9'h1FF) rx_count++;
      rx_crc = crc16_add(rx_crc, w.data_byte);
      if (rx_count == FC_POS) rx_func = w.data_byte;
      if (rx_count == DECODE_POS) begin
        case (rx_func)
          FC_READ_HOLDING: rx_expect_len = LEN_FC03_HDR + w.data_byte;
          FC_WRITE_SINGLE: rx_expect_len = {1'b0, rx_req_len};
          FC_WRITE_MULTI:  rx_expect_len = LEN_FC10;
          FC_EXC_READ, FC_EXC_WRITE: rx_expect_len = LEN_EXCEPT;
          default: begin
            rx_busy = 1'b0;
            r = result_of(ST_UNKNOWN);
            return 1'b1;
          end
        endcase
      end
      if (rx_count >= rx_expect_len) begin
        rx_busy = 1'b0;
        r = result_of(rx_crc == 16'h0000 ? ST_OK : ST_CRC_ERR);
        return 1'b1;
      end
      return 1'b0;
    end
    if (w.opcode == OP_TICK) begin
      if (rx_ticks != 16'hFFFF) rx_ticks++;
      if (rx_ticks >= timeout_setting) begin
        if ({1'b0, rx_attempt} + 5'd1 < {1'b0, retry_setting}) begin
          r = result_of(ST_RETRANSMIT);
          rx_attempt++;
          open_attempt();
        end else begin
          r = result_of(ST_TIMEOUT);
          rx_busy = 1'b0;
        end
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Idle length for one side: mostly none, some short, a few long, and quiet stretches
  function automatic int draw_gap(input int side);
    int roll;
    if (quiet_left[side] > 0) begin
      quiet_left[side]--;
      return 0;
    end
    roll = $urandom_range(0, 199);
    if (roll == 0) begin
      quiet_left[side] = $urandom_range(40, 160);
      return 0;
    end
    if (roll < 130) return 0;
    if (roll < 190) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(input string name, input logic [8:0] want,
                                      input logic [8:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Request driver: predicts each word as it is taken
  always @(posedge clk) begin : drive_req
    rsp_word_t predicted;
    int        send_gap;
    if (rst) begin
      req_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_valid && !req_stall) begin
        words_taken++;
        if (predict_rx_result(req_word, predicted)) awaited_rsp.push_back(predicted);
        send_gap = draw_gap(0);
      end
      if (!req_valid || !req_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (queued_req.size() != 0) begin
          req_word <= queued_req.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed by the stimulus
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Result checker and receiver stalls
  always @(posedge clk) begin : watch_rsp
    rsp_word_t want;
    int        stall_gap;
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_gap = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got status %0d length %0d %s %0d",
                   $time, rsp_word.status, rsp_word.frame_length, "attempt",
                   rsp_word.attempt_number);
          mismatches++;
        end else begin
          want = awaited_rsp.pop_front();
          results_seen++;
          status_seen[want.status]++;
          check_field("status", 9'(want.status), 9'(rsp_word.status));
          check_field("frame_length", want.frame_length, rsp_word.frame_length);
          check_field("attempt_number", 9'(want.attempt_number),
                      9'(rsp_word.attempt_number));
        end
      end
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
      end else if (stall_gap > 0) begin
        stall_gap--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        stall_gap = draw_gap(1);
      end
    end
  end

  task automatic push_word(input logic [1:0] op, input logic [7:0] d, input logic [7:0] rl);
    req_word_t w;
    w.opcode = opcode_t'(op);
    w.data_byte = d;
    w.request_length = rl;
    queued_req.push_back(w);
  endtask

  task automatic push_start(input logic [7:0] rl);
    push_word(OP_START, 8'($urandom_range(0, 255)), rl);
  endtask

  task automatic push_tick();
    push_word(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Append the CRC, low byte first, so the residue over the whole frame is zero
  task automatic seal_frame();
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (frame_bytes[i]) c = crc16_add(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endtask

  task automatic push_frame_bytes(input int tick_odds);
    foreach (frame_bytes[i]) begin
      if (tick_odds > 0 && $urandom_range(1, tick_odds) == 1) push_tick();
      push_word(OP_BYTE, frame_bytes[i], 8'($urandom_range(0, 255)));
    end
  endtask

  // One request/response exchange: failed attempts, then a mostly well-formed frame
  task automatic queue_exchange();
    logic [7:0] fc;
    logic [7:0] rl;
    int kind, body, fails, cut, pos;
    kind = $urandom_range(0, 9);
    rl = 8'($urandom_range(0, 255));
    frame_bytes.delete();
    frame_bytes.push_back(8'($urandom_range(0, 255)));
    case (kind)
      0, 1, 2, 3: begin
        fc = FC_READ_HOLDING;
        body = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        frame_bytes.push_back(fc);
        frame_bytes.push_back(8'(body));
      end
      4, 5: begin
        fc = FC_WRITE_SINGLE;
        rl = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'd8;
        body = (rl > 4) ? rl - 4 : 0;
        frame_bytes.push_back(fc);
      end
      6: begin
        fc = FC_WRITE_MULTI;
        body = 4;
        frame_bytes.push_back(fc);
      end
      7: begin
        fc = $urandom_range(0, 1) ? FC_EXC_READ : FC_EXC_WRITE;
        body = 1;
        frame_bytes.push_back(fc);
      end
      8: begin
        do fc = 8'($urandom_range(0, 255));
        while (fc == FC_READ_HOLDING || fc == FC_WRITE_SINGLE || fc == FC_WRITE_MULTI ||
               fc == FC_EXC_READ || fc == FC_EXC_WRITE);
        body = 1;
        frame_bytes.push_back(fc);
      end
      default: begin
        fc = 8'($urandom_range(0, 255));
        body = $urandom_range(0, 6);
        frame_bytes.push_back(fc);
      end
    endcase
    repeat (body) frame_bytes.push_back(8'($urandom_range(0, 255)));
    seal_frame();
    // flipped bit gives a CRC error (or a different function code)
    if ($urandom_range(0, 7) == 0) begin
      pos = $urandom_range(0, frame_bytes.size() - 1);
      frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, frame_bytes.size() - 1) : 0;
    repeat (cut) void'(frame_bytes.pop_back());

    push_start(rl);
    fails = 0;
    if ($urandom_range(0, 3) == 0 && timeout_setting <= 40)
      fails = $urandom_range(1, (retry_setting > 1) ? retry_setting : 1);
    repeat (fails) begin
      repeat ($urandom_range(0, 2))
        push_word(OP_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      repeat ((timeout_setting > 0) ? timeout_setting : 1) push_tick();
    end
    push_frame_bytes(10);
    if (cut > 0 && timeout_setting <= 40) repeat (timeout_setting + 1) push_tick();
  endtask

  // Random words between exchanges: any opcode, any fields
  task automatic queue_noise();
    repeat ($urandom_range(1, 3))
      push_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (queued_req.size() != 0 || req_valid || awaited_rsp.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_TIMEOUT_TICKS) timeout_setting = value;
    else retry_setting = value[3:0];
  endtask

  // Stimulus: directed words, then random phases over several register settings
  initial begin
    int          phase_timeout[PHASES] = '{1, 65535, 0, 4, 12, 0, 2};
    int          phase_retry[PHASES] = '{1, 15, 0, 15, 3, 0, 2};
    logic [15:0] retry_word;
    int          mark, phase_count;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // idle words, then a good write-multiple reply under reset settings
    push_word(OP_BYTE, 8'hFF, 8'hFF);
    push_word(OP_TICK, 8'h00, 8'h00);
    push_word(OP_UNUSED, 8'hFF, 8'hFF);
    push_start(8'hFF);
    frame_bytes = '{8'hFF, FC_WRITE_MULTI, 8'h00, 8'h00, 8'hFF, 8'hFF};
    seal_frame();
    push_frame_bytes(0);
    wait_idle();

    write_reg(CFG_TIMEOUT_TICKS, 16'd2);
    write_reg(CFG_RETRY_LIMIT, 16'd2);
    settings_used++;
    // write-single reply with zero request length ends at the third byte
    push_start(8'h00);
    push_word(OP_BYTE, 8'h00, 8'h00);
    push_word(OP_BYTE, FC_WRITE_SINGLE, 8'hFF);
    push_word(OP_BYTE, 8'h00, 8'h00);
    // unknown function code
    push_start(8'h03);
    push_word(OP_BYTE, 8'h01, 8'h00);
    push_word(OP_BYTE, 8'h42, 8'h00);
    push_word(OP_BYTE, 8'hFF, 8'h00);
    // restart while busy, then retransmit and final timeout
    push_start(8'h08);
    push_start(8'h08);
    push_word(OP_BYTE, 8'h11, 8'h00);
    repeat (4) push_tick();
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      if (p == 5) begin
        phase_timeout[p] = $urandom_range(1, 30);
        phase_retry[p] = $urandom_range(1, 15);
      end
      write_reg(CFG_TIMEOUT_TICKS, 16'(phase_timeout[p]));
      retry_word = 16'($urandom_range(0, 65535));
      retry_word[3:0] = 4'(phase_retry[p]);
      write_reg(CFG_RETRY_LIMIT, retry_word);
      settings_used++;
      // hold results back so the block fills and stalls its input
      if (p == 0 || p == 3) hold_left <= HOLD_CYCLES;
      phase_count = 0;
      while (phase_count < PHASE_WORDS) begin
        mark = queued_req.size();
        queue_exchange();
        phase_count += queued_req.size() - mark;
        if ($urandom_range(0, 5) == 0) queue_noise();
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d words and %0d results over %0d register settings", words_taken,
             results_seen, settings_used);
    $display("results: %0d ok, %0d crc error, %0d timeout, %0d unknown, %0d retransmit",
             status_seen[ST_OK], status_seen[ST_CRC_ERR], status_seen[ST_TIMEOUT],
             status_seen[ST_UNKNOWN], status_seen[ST_RETRANSMIT]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("run limit reached with %0d results outstanding", awaited_rsp.size());
    $display("status: fail");
    $finish;
  end

endmodule

[files.f]
sv/mrr_pkg.sv
sv/mrr_cfg.sv
sv/mrr_engine.sv
sv/modbus_rtu_response_receiver.sv
sv/mrr_checker.sv
tb/modbus_rtu_response_receiver_tb.sv
